FILE: rtl/obb_pkg.sv
// Shared definitions for the orthonormal basis builder: widths, fixed-point
// constants, mode codes, request and result types and the mode decoder.
// No dependencies.
package obb_pkg;

  localparam int IN_W       = 16;             // raw vector component width
  localparam int FRAC       = 14;             // fraction bits of an axis component
  localparam int AX_W       = 16;             // axis component width
  localparam int PR_W       = 2 * IN_W;       // product of two raw components
  localparam int VW         = PR_W + 1;       // raw cross product component
  localparam int MAG_W      = PR_W;           // magnitude of a raw component
  localparam int POS_W      = $clog2(MAG_W);  // bit position within a magnitude
  localparam int NM_W       = 30;             // largest magnitude scaled into [2^29, 2^30)
  localparam int SQ_W       = 2 * NM_W + 2;   // sum of three squares
  localparam int ROOT_STEPS = SQ_W / 2;       // one result bit per square root step
  localparam int ROOT_W     = NM_W + 1;       // vector length
  localparam int Q_W        = FRAC + 1;       // quotient of one component
  localparam int NUM_W      = NM_W + FRAC + 1;
  // magnitude, max, position, shift, squares, sum, root, setup, divide, sign
  localparam int NORM_LAT   = 6 + ROOT_STEPS + 1 + Q_W + 1;
  localparam int EPS_SQ     = (1 << (2 * FRAC)) / 10000;

  typedef logic signed [IN_W-1:0] in_t;
  typedef logic signed [AX_W-1:0] axis_t;

  localparam axis_t ONE_Q = axis_t'(1 << FRAC);

  localparam logic [3:0] MODE_U  = 4'd0;
  localparam logic [3:0] MODE_V  = 4'd1;
  localparam logic [3:0] MODE_W  = 4'd2;
  localparam logic [3:0] MODE_UV = 4'd3;
  localparam logic [3:0] MODE_VU = 4'd4;
  localparam logic [3:0] MODE_UW = 4'd5;
  localparam logic [3:0] MODE_WU = 4'd6;
  localparam logic [3:0] MODE_VW = 4'd7;
  localparam logic [3:0] MODE_WV = 4'd8;

  localparam logic [1:0] SLOT_U = 2'd0;
  localparam logic [1:0] SLOT_V = 2'd1;
  localparam logic [1:0] SLOT_W = 2'd2;

  typedef struct packed {
    logic [3:0] mode;
    in_t        first_x;
    in_t        first_y;
    in_t        first_z;
    in_t        second_x;
    in_t        second_y;
    in_t        second_z;
  } vec_item_t;

  typedef struct packed {
    axis_t u_x;
    axis_t u_y;
    axis_t u_z;
    axis_t v_x;
    axis_t v_y;
    axis_t v_z;
    axis_t w_x;
    axis_t w_y;
    axis_t w_z;
    logic  degenerate;
  } basis_item_t;

  // A is the normalized first vector, B the second axis, C = cross of the two
  typedef struct packed {
    logic       known;
    logic       two;     // second axis from the normalized raw cross product
    logic       neg2;    // raw cross product taken as second x first
    logic       swap;    // C = cross(B, A) rather than cross(A, B)
    logic [1:0] a_slot;
    logic [1:0] b_slot;
  } mode_ctl_t;

  function automatic mode_ctl_t mode_decode(input logic [3:0] mode);
    mode_ctl_t c;
    c = '{known: 1'b1, two: 1'b0, neg2: 1'b0, swap: 1'b0,
          a_slot: SLOT_U, b_slot: SLOT_V};
    unique case (mode)
      MODE_U:  begin c.a_slot = SLOT_U; c.b_slot = SLOT_V; end
      MODE_V:  begin c.a_slot = SLOT_V; c.b_slot = SLOT_U; c.swap = 1'b1; end
      MODE_W:  begin c.a_slot = SLOT_W; c.b_slot = SLOT_U; end
      MODE_UV: begin
        c.two = 1'b1; c.swap = 1'b1; c.a_slot = SLOT_U; c.b_slot = SLOT_W;
      end
      MODE_VU: begin
        c.two = 1'b1; c.neg2 = 1'b1; c.a_slot = SLOT_V; c.b_slot = SLOT_W;
      end
      MODE_UW: begin
        c.two = 1'b1; c.neg2 = 1'b1; c.a_slot = SLOT_U; c.b_slot = SLOT_V;
      end
      MODE_WU: begin
        c.two = 1'b1; c.swap = 1'b1; c.a_slot = SLOT_W; c.b_slot = SLOT_V;
      end
      MODE_VW: begin
        c.two = 1'b1; c.swap = 1'b1; c.a_slot = SLOT_V; c.b_slot = SLOT_U;
      end
      MODE_WV: begin
        c.two = 1'b1; c.neg2 = 1'b1; c.a_slot = SLOT_W; c.b_slot = SLOT_U;
      end
      default: c.known = 1'b0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/obb_stream_if.sv
// Valid/ready stream channel carrying one request or result per transfer.
// Payload type is set per instance; depends on nothing else.
interface obb_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/orthonormal_basis_builder.sv
// Orthonormal basis builder, top level.
// Depends on obb_pkg, obb_stream_if and obb_norm.
//
// Usage: requests arrive on vec (mode plus one or two signed 16-bit 3-vectors)
// and one result per request leaves on basis: axes U, V, W in signed Q1.14 and
// a degenerate flag, set when a vector to normalize had zero length or the mode
// is unknown (unknown modes give all-zero axes).
// Both channels transfer on a clock edge with valid and ready high.
// Throughput: one request per cycle while vec.ready is high. Results reach
// basis.valid through the normalizer: 31 square root stages and 15 divide
// stages, one bit each, plus raw cross product, scaling and the final cross
// product stages.
// Stall: a stalled result moves into a skid register while the next result
// fills the output register, after which the pipeline freezes and vec.ready
// drops until the skid register empties. Nothing is lost or repeated.
// Reset (rst, synchronous): clears all valid bits and the skid valid flag; the
// block takes requests in the first cycle after reset.
module orthonormal_basis_builder (
  input logic        clk,
  input logic        rst,
  obb_stream_if.sink   vec,
  obb_stream_if.source basis
);

  localparam int NL       = obb_pkg::NORM_LAT;
  localparam int NORM_OUT = 2 + NL;
  localparam int DEPTH    = NORM_OUT + 6;
  localparam int PW       = obb_pkg::PR_W;
  localparam obb_pkg::axis_t HALF_Q = obb_pkg::ONE_Q >>> 1;

  logic                 en;
  logic [DEPTH-1:0]     vld;
  logic                 skid_v;
  obb_pkg::basis_item_t skid;
  obb_pkg::basis_item_t res;

  logic [3:0]         mode0, mode1, mode2;
  obb_pkg::in_t       f0 [3];
  obb_pkg::in_t       s0 [3];
  obb_pkg::in_t       f1 [3];
  logic signed [PW-1:0] p1 [6];
  logic signed [obb_pkg::VW-1:0] f2 [3];
  logic signed [obb_pkg::VW-1:0] c2 [3];
  logic [3:0]         md [NL];

  obb_pkg::axis_t     n1q [3];
  obb_pkg::axis_t     n2q [3];
  logic               n1z, n2z;
  obb_pkg::mode_ctl_t ctl_n;

  obb_pkg::mode_ctl_t ctl1, ctl2, ctl3, ctl4;
  obb_pkg::axis_t     a1 [3], a2 [3], a3 [3], a4 [3];
  obb_pkg::axis_t     n2s1 [3];
  obb_pkg::axis_t     b_n [3], b2 [3], b3 [3], b4 [3];
  obb_pkg::axis_t     cx [3], cy [3];
  obb_pkg::axis_t     c4 [3];
  logic signed [PW-1:0] sqy1, sqz1;
  logic signed [PW-1:0] pr3 [6];
  logic               deg1, deg2, deg3, deg4;
  logic               near_axis;
  obb_pkg::axis_t     sv [3][3];
  obb_pkg::basis_item_t res_next;

  function automatic obb_pkg::axis_t round_clamp(input logic signed [PW-1:0] x,
                                                 input logic signed [PW-1:0] y);
    logic signed [PW:0] d;
    logic signed [PW:0] r;
    d = $signed({x[PW-1], x}) - $signed({y[PW-1], y});
    r = (d + (PW+1)'(1 << (obb_pkg::FRAC - 1))) >>> obb_pkg::FRAC;
    if (r > obb_pkg::ONE_Q) r = (PW+1)'(obb_pkg::ONE_Q);
    if (r < -obb_pkg::ONE_Q) r = -(PW+1)'(obb_pkg::ONE_Q);
    return obb_pkg::AX_W'(r);
  endfunction

  assign en        = !skid_v;
  assign vec.ready = en;
  assign basis.valid = skid_v | vld[DEPTH-1];
  assign basis.data  = skid_v ? skid : res;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], vec.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (basis.ready) skid_v <= 1'b0;
    end else if (vld[DEPTH-1] && !basis.ready) begin
      skid_v <= 1'b1;
    end
  end

  // hold the stalled result before the output register is refilled
  always_ff @(posedge clk) begin
    if (en) skid <= res;
  end

  // raw cross product of first and second vector
  always_ff @(posedge clk) begin
    if (en) begin
      mode0 <= vec.data.mode;
      f0[0] <= vec.data.first_x;
      f0[1] <= vec.data.first_y;
      f0[2] <= vec.data.first_z;
      s0[0] <= vec.data.second_x;
      s0[1] <= vec.data.second_y;
      s0[2] <= vec.data.second_z;

      mode1 <= mode0;
      p1[0] <= f0[1] * s0[2];
      p1[1] <= f0[2] * s0[1];
      p1[2] <= f0[2] * s0[0];
      p1[3] <= f0[0] * s0[2];
      p1[4] <= f0[0] * s0[1];
      p1[5] <= f0[1] * s0[0];
      for (int i = 0; i < 3; i++) f1[i] <= f0[i];

      mode2 <= mode1;
      for (int i = 0; i < 3; i++) begin
        f2[i] <= obb_pkg::VW'(f1[i]);
        c2[i] <= obb_pkg::VW'(p1[2*i]) - obb_pkg::VW'(p1[2*i+1]);
      end

      md[0] <= mode2;
      for (int k = 1; k < NL; k++) md[k] <= md[k-1];
    end
  end

  obb_norm u_norm_first (
    .clk  (clk),
    .en   (en),
    .vin  (f2),
    .q    (n1q),
    .zero (n1z)
  );

  obb_norm u_norm_cross (
    .clk  (clk),
    .en   (en),
    .vin  (c2),
    .q    (n2q),
    .zero (n2z)
  );

  assign ctl_n = obb_pkg::mode_decode(md[NL-1]);
  assign near_axis = (sqy1 + sqz1) < obb_pkg::EPS_SQ;

  always_comb begin
    if (ctl1.two) begin
      for (int i = 0; i < 3; i++) b_n[i] = n2s1[i];
    end else if (near_axis) begin
      // cross with the y axis
      b_n[0] = -a1[2];
      b_n[1] = '0;
      b_n[2] = a1[0];
    end else begin
      b_n[0] = '0;
      b_n[1] = a1[2];
      b_n[2] = -a1[1];
    end
    for (int i = 0; i < 3; i++) begin
      cx[i] = ctl2.swap ? b2[i] : a2[i];
      cy[i] = ctl2.swap ? a2[i] : b2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1 <= ctl_n;
      deg1 <= !ctl_n.known || n1z || (ctl_n.two && n2z);
      sqy1 <= n1q[1] * n1q[1];
      sqz1 <= n1q[2] * n1q[2];
      for (int i = 0; i < 3; i++) begin
        a1[i]   <= n1q[i];
        n2s1[i] <= ctl_n.neg2 ? -n2q[i] : n2q[i];
      end

      ctl2 <= ctl1;
      deg2 <= deg1;
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a1[i];
        b2[i] <= b_n[i];
      end

      ctl3 <= ctl2;
      deg3 <= deg2;
      pr3[0] <= cx[1] * cy[2];
      pr3[1] <= cx[2] * cy[1];
      pr3[2] <= cx[2] * cy[0];
      pr3[3] <= cx[0] * cy[2];
      pr3[4] <= cx[0] * cy[1];
      pr3[5] <= cx[1] * cy[0];
      for (int i = 0; i < 3; i++) begin
        a3[i] <= a2[i];
        b3[i] <= b2[i];
      end

      ctl4 <= ctl3;
      deg4 <= deg3;
      for (int i = 0; i < 3; i++) begin
        a4[i] <= a3[i];
        b4[i] <= b3[i];
        c4[i] <= round_clamp(pr3[2*i], pr3[2*i+1]);
      end

      res <= res_next;
    end
  end

  // place A, B and C into their axes
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (!ctl4.known) begin
          sv[s][i] = '0;
        end else if (ctl4.a_slot == 2'(s)) begin
          sv[s][i] = a4[i];
        end else if (ctl4.b_slot == 2'(s)) begin
          sv[s][i] = b4[i];
        end else begin
          sv[s][i] = c4[i];
        end
      end
    end
    res_next.u_x = sv[obb_pkg::SLOT_U][0];
    res_next.u_y = sv[obb_pkg::SLOT_U][1];
    res_next.u_z = sv[obb_pkg::SLOT_U][2];
    res_next.v_x = sv[obb_pkg::SLOT_V][0];
    res_next.v_y = sv[obb_pkg::SLOT_V][1];
    res_next.v_z = sv[obb_pkg::SLOT_V][2];
    res_next.w_x = sv[obb_pkg::SLOT_W][0];
    res_next.w_y = sv[obb_pkg::SLOT_W][1];
    res_next.w_z = sv[obb_pkg::SLOT_W][2];
    res_next.degenerate = deg4;
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(vld[DEPTH-1] && !basis.ready))
    else $error("skid register filled without a stalled result");

  assert property (@(posedge clk) disable iff (rst)
    skid_v |=> $stable(vld))
    else $error("pipeline advanced while the skid register was full");

  assert property (@(posedge clk) disable iff (rst)
    (vld[NORM_OUT] && !n1z) |->
      (n1q[0] >= HALF_Q || n1q[0] <= -HALF_Q || n1q[1] >= HALF_Q ||
       n1q[1] <= -HALF_Q || n1q[2] >= HALF_Q || n1q[2] <= -HALF_Q))
    else $error("normalized vector too short");

  assert property (@(posedge clk) disable iff (rst)
    (vld[NORM_OUT] && n1z) |-> (n1q[0] == '0 && n1q[1] == '0 && n1q[2] == '0))
    else $error("zero vector normalized to a non-zero value");

endmodule

FILE: rtl/obb_norm.sv
// Pipelined vector normalizer: scale, square root and per-component divide.
// Depends on obb_pkg; stage advance comes from the enclosing pipeline.
module obb_norm (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [obb_pkg::VW-1:0] vin [3],
  output obb_pkg::axis_t               q [3],
  output logic                         zero
);

  localparam int RS = obb_pkg::ROOT_STEPS;
  localparam int DS = obb_pkg::Q_W;
  localparam logic [obb_pkg::Q_W-1:0] Q_ONE = obb_pkg::Q_W'(1) << obb_pkg::FRAC;

  logic signed [obb_pkg::VW-1:0] ab [3];
  logic [obb_pkg::MAG_W-1:0] ma [3];
  logic                      na [3];

  logic [obb_pkg::MAG_W-1:0] mx_n;
  logic [obb_pkg::MAG_W-1:0] mb [3];
  logic [obb_pkg::MAG_W-1:0] mxb;
  logic                      nb [3];

  logic [obb_pkg::POS_W-1:0] pos_n;
  logic [obb_pkg::MAG_W-1:0] mc [3];
  logic [obb_pkg::POS_W-1:0] pc;
  logic                      zc;
  logic                      nc [3];

  logic [obb_pkg::MAG_W-1:0] sh_n [3];
  logic [obb_pkg::NM_W-1:0]  md [3];
  logic                      zd;
  logic                      nd [3];

  logic [2*obb_pkg::NM_W-1:0] se [3];
  logic [obb_pkg::NM_W-1:0]   me [3];
  logic                       ze;
  logic                       ne [3];

  logic [obb_pkg::SQ_W-1:0] rn [RS+1];
  logic [obb_pkg::SQ_W-1:0] rr [RS+1];
  logic [obb_pkg::NM_W-1:0] rm [RS+1][3];
  logic                     rneg [RS+1][3];
  logic                     rz [RS+1];
  logic [obb_pkg::SQ_W-1:0] rn_next [RS];
  logic [obb_pkg::SQ_W-1:0] rr_next [RS];

  logic [obb_pkg::ROOT_W-1:0] len;
  logic [obb_pkg::NUM_W-1:0]  dn [DS+1][3];
  logic [obb_pkg::Q_W-1:0]    dq [DS+1][3];
  logic [obb_pkg::ROOT_W-1:0] dl [DS+1];
  logic                       dneg [DS+1][3];
  logic                       dz [DS+1];
  logic [obb_pkg::NUM_W-1:0]  dn_next [DS][3];
  logic [obb_pkg::Q_W-1:0]    dq_next [DS][3];

  obb_pkg::axis_t q_next [3];

  function automatic logic [obb_pkg::POS_W-1:0] top_bit(input logic [obb_pkg::MAG_W-1:0] x);
    logic [obb_pkg::POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < obb_pkg::MAG_W; i++) begin
      if (x[i]) p = obb_pkg::POS_W'(i);
    end
    return p;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = (vin[i] < 0) ? -vin[i] : vin[i];
    end
    mx_n = ma[0];
    if (ma[1] > mx_n) mx_n = ma[1];
    if (ma[2] > mx_n) mx_n = ma[2];
    pos_n = top_bit(mxb);
    // bring the largest magnitude to bit NM_W-1; right shifts truncate
    for (int i = 0; i < 3; i++) begin
      if (pc >= obb_pkg::POS_W'(obb_pkg::NM_W - 1)) begin
        sh_n[i] = mc[i] >> (pc - obb_pkg::POS_W'(obb_pkg::NM_W - 1));
      end else begin
        sh_n[i] = mc[i] << (obb_pkg::POS_W'(obb_pkg::NM_W - 1) - pc);
      end
    end
  end

  // one square root bit per stage
  always_comb begin
    logic [obb_pkg::SQ_W-1:0] bitv;
    logic [obb_pkg::SQ_W-1:0] t;
    for (int k = 0; k < RS; k++) begin
      bitv = obb_pkg::SQ_W'(1) << (2 * (RS - 1 - k));
      t = rr[k] + bitv;
      if (rn[k] >= t) begin
        rn_next[k] = rn[k] - t;
        rr_next[k] = (rr[k] >> 1) + bitv;
      end else begin
        rn_next[k] = rn[k];
        rr_next[k] = rr[k] >> 1;
      end
    end
  end

  // one quotient bit per stage, three lanes
  always_comb begin
    logic [obb_pkg::NUM_W-1:0] cmp;
    for (int k = 0; k < DS; k++) begin
      cmp = obb_pkg::NUM_W'(dl[k]) << (DS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (dn[k][i] >= cmp) begin
          dn_next[k][i] = dn[k][i] - cmp;
          dq_next[k][i] = dq[k][i] | (obb_pkg::Q_W'(1) << (DS - 1 - k));
        end else begin
          dn_next[k][i] = dn[k][i];
          dq_next[k][i] = dq[k][i];
        end
      end
    end
  end

  assign len = rr[RS][obb_pkg::ROOT_W-1:0];

  always_comb begin
    logic [obb_pkg::Q_W-1:0] qv;
    for (int i = 0; i < 3; i++) begin
      qv = dq[DS][i];
      if (qv > Q_ONE) qv = Q_ONE;
      if (dz[DS]) begin
        q_next[i] = '0;
      end else if (dneg[DS][i]) begin
        q_next[i] = -$signed(obb_pkg::AX_W'(qv));
      end else begin
        q_next[i] = $signed(obb_pkg::AX_W'(qv));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma[i] <= ab[i][obb_pkg::MAG_W-1:0];
        na[i] <= vin[i][obb_pkg::VW-1];
        mb[i] <= ma[i];
        nb[i] <= na[i];
        mc[i] <= mb[i];
        nc[i] <= nb[i];
        md[i] <= sh_n[i][obb_pkg::NM_W-1:0];
        nd[i] <= nc[i];
        se[i] <= md[i] * md[i];
        me[i] <= md[i];
        ne[i] <= nd[i];
      end
      mxb <= mx_n;
      pc  <= pos_n;
      zc  <= (mxb == '0);
      zd  <= zc;
      ze  <= zd;

      rn[0] <= obb_pkg::SQ_W'(se[0]) + obb_pkg::SQ_W'(se[1]) + obb_pkg::SQ_W'(se[2]);
      rr[0] <= '0;
      rz[0] <= ze;
      for (int i = 0; i < 3; i++) begin
        rm[0][i]   <= me[i];
        rneg[0][i] <= ne[i];
      end
      for (int k = 0; k < RS; k++) begin
        rn[k+1] <= rn_next[k];
        rr[k+1] <= rr_next[k];
        rz[k+1] <= rz[k];
        for (int i = 0; i < 3; i++) begin
          rm[k+1][i]   <= rm[k][i];
          rneg[k+1][i] <= rneg[k][i];
        end
      end

      // round half up: add half the length before dividing
      dl[0] <= len;
      dz[0] <= rz[RS];
      for (int i = 0; i < 3; i++) begin
        dn[0][i]   <= (obb_pkg::NUM_W'(rm[RS][i]) << obb_pkg::FRAC)
                      + obb_pkg::NUM_W'(len >> 1);
        dq[0][i]   <= '0;
        dneg[0][i] <= rneg[RS][i];
      end
      for (int k = 0; k < DS; k++) begin
        dl[k+1] <= dl[k];
        dz[k+1] <= dz[k];
        for (int i = 0; i < 3; i++) begin
          dn[k+1][i]   <= dn_next[k][i];
          dq[k+1][i]   <= dq_next[k][i];
          dneg[k+1][i] <= dneg[k][i];
        end
      end

      for (int i = 0; i < 3; i++) begin
        q[i] <= q_next[i];
      end
      zero <= dz[DS];
    end
  end

endmodule

FILE: tb/tb_orthonormal_basis_builder.sv
// Testbench for orthonormal_basis_builder: directed table then random requests,
// each result checked against an in-bench fixed-point basis predictor.
// Depends on obb_pkg, obb_stream_if and the orthonormal_basis_builder RTL.
module tb_orthonormal_basis_builder;

  localparam logic [3:0] MODE_SPARE_LO = obb_pkg::MODE_WV + 4'd1;
  localparam logic [3:0] MODE_SPARE_HI = 4'hF;
  localparam longint     Q_ONE         = longint'(1) << obb_pkg::FRAC;
  localparam longint     SMALL_SQ      = (longint'(1) << (2 * obb_pkg::FRAC)) / 10000;
  localparam int         TAIL_CYCLES   = 100;

  typedef struct {
    longint c[3];
  } vec3_t;

  typedef struct {
    obb_pkg::vec_item_t   req;
    bit                   typed;
    obb_pkg::basis_item_t want;
  } row_t;

  logic clk;
  logic rst;
  obb_stream_if #(.item_t(obb_pkg::vec_item_t))   vec ();
  obb_stream_if #(.item_t(obb_pkg::basis_item_t)) basis ();

  orthonormal_basis_builder uut (
    .clk   (clk),
    .rst   (rst),
    .vec   (vec),
    .basis (basis)
  );

  obb_pkg::basis_item_t pending_bases[$];
  row_t        rows[$];
  int          errors;
  int          accepted;
  int          checked;
  int          degen_seen;
  int          mode_hits[16];
  int          stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL orthonormal_basis_builder");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint round_q(longint x);
    longint y;
    y = (x + (longint'(1) << (obb_pkg::FRAC - 1))) >>> obb_pkg::FRAC;
    if (y > Q_ONE) y = Q_ONE;
    if (y < -Q_ONE) y = -Q_ONE;
    return y;
  endfunction

  function automatic vec3_t cross_axes(vec3_t a, vec3_t b);
    vec3_t r;
    r.c[0] = round_q(a.c[1] * b.c[2] - a.c[2] * b.c[1]);
    r.c[1] = round_q(a.c[2] * b.c[0] - a.c[0] * b.c[2]);
    r.c[2] = round_q(a.c[0] * b.c[1] - a.c[1] * b.c[0]);
    return r;
  endfunction

  function automatic vec3_t cross_exact(vec3_t a, vec3_t b);
    vec3_t r;
    r.c[0] = a.c[1] * b.c[2] - a.c[2] * b.c[1];
    r.c[1] = a.c[2] * b.c[0] - a.c[0] * b.c[2];
    r.c[2] = a.c[0] * b.c[1] - a.c[1] * b.c[0];
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_axis(vec3_t a, inout bit deg);
    longint unsigned m[3], mx, l, q;
    vec3_t r;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (a.c[i] < 0) ? -a.c[i] : a.c[i];
      if (m[i] > mx) mx = m[i];
      r.c[i] = 0;
    end
    if (mx == 0) begin
      deg = 1'b1;
      return r;
    end
    while (mx >= (longint'(1) << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (longint'(1) << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    l = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << obb_pkg::FRAC) + l / 2) / l;
      if (q > Q_ONE) q = Q_ONE;
      r.c[i] = (a.c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic vec3_t mk(longint x, longint y, longint z);
    vec3_t r;
    r.c[0] = x;
    r.c[1] = y;
    r.c[2] = z;
    return r;
  endfunction

  // cross with x, falling back to y when the product is nearly zero
  function automatic vec3_t side_axis(vec3_t a);
    vec3_t r;
    r = cross_axes(a, mk(Q_ONE, 0, 0));
    if (r.c[0] * r.c[0] + r.c[1] * r.c[1] + r.c[2] * r.c[2] < SMALL_SQ)
      r = cross_axes(a, mk(0, Q_ONE, 0));
    return r;
  endfunction

  function automatic obb_pkg::basis_item_t predict_basis(obb_pkg::vec_item_t it);
    vec3_t f, s, u, v, w;
    bit deg;
    obb_pkg::basis_item_t b;
    f = mk(it.first_x, it.first_y, it.first_z);
    s = mk(it.second_x, it.second_y, it.second_z);
    u = mk(0, 0, 0);
    v = u;
    w = u;
    deg = 1'b0;
    case (it.mode)
      obb_pkg::MODE_U:  begin u = unit_axis(f, deg); v = side_axis(u); w = cross_axes(u, v); end
      obb_pkg::MODE_V:  begin v = unit_axis(f, deg); u = side_axis(v); w = cross_axes(u, v); end
      obb_pkg::MODE_W:  begin w = unit_axis(f, deg); u = side_axis(w); v = cross_axes(w, u); end
      obb_pkg::MODE_UV: begin
        u = unit_axis(f, deg); w = unit_axis(cross_exact(f, s), deg); v = cross_axes(w, u);
      end
      obb_pkg::MODE_VU: begin
        v = unit_axis(f, deg); w = unit_axis(cross_exact(s, f), deg); u = cross_axes(v, w);
      end
      obb_pkg::MODE_UW: begin
        u = unit_axis(f, deg); v = unit_axis(cross_exact(s, f), deg); w = cross_axes(u, v);
      end
      obb_pkg::MODE_WU: begin
        w = unit_axis(f, deg); v = unit_axis(cross_exact(f, s), deg); u = cross_axes(v, w);
      end
      obb_pkg::MODE_VW: begin
        v = unit_axis(f, deg); u = unit_axis(cross_exact(f, s), deg); w = cross_axes(u, v);
      end
      obb_pkg::MODE_WV: begin
        w = unit_axis(f, deg); u = unit_axis(cross_exact(s, f), deg); v = cross_axes(w, u);
      end
      default: deg = 1'b1;
    endcase
    b.u_x = obb_pkg::axis_t'(u.c[0]);
    b.u_y = obb_pkg::axis_t'(u.c[1]);
    b.u_z = obb_pkg::axis_t'(u.c[2]);
    b.v_x = obb_pkg::axis_t'(v.c[0]);
    b.v_y = obb_pkg::axis_t'(v.c[1]);
    b.v_z = obb_pkg::axis_t'(v.c[2]);
    b.w_x = obb_pkg::axis_t'(w.c[0]);
    b.w_y = obb_pkg::axis_t'(w.c[1]);
    b.w_z = obb_pkg::axis_t'(w.c[2]);
    b.degenerate = deg;
    return b;
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    obb_pkg::basis_item_t want, got;
    if (!rst && basis.valid && basis.ready) begin
      got = basis.data;
      if (pending_bases.size() == 0) begin
        $error("unexpected basis result");
        errors++;
      end else begin
        want = pending_bases.pop_front();
        check_field("u_x", want.u_x, got.u_x);
        check_field("u_y", want.u_y, got.u_y);
        check_field("u_z", want.u_z, got.u_z);
        check_field("v_x", want.v_x, got.v_x);
        check_field("v_y", want.v_y, got.v_y);
        check_field("v_z", want.v_z, got.v_z);
        check_field("w_x", want.w_x, got.w_x);
        check_field("w_y", want.w_y, got.w_y);
        check_field("w_z", want.w_z, got.w_z);
        check_field("degenerate", want.degenerate, got.degenerate);
        checked++;
        if (got.degenerate) degen_seen++;
      end
    end
  end

  // receiver stall pattern: basis.ready drops at a stall rate redrawn from 0, 20, 60 or 90 percent
  int rx_cycle;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 20;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    basis.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ---------------- stimulus ----------------
  task automatic add_row(logic [3:0] mode, int fx, int fy, int fz, int sx, int sy, int sz,
                         bit typed, obb_pkg::basis_item_t want);
    row_t r;
    r.req = '{mode: mode,
              first_x: obb_pkg::in_t'(fx), first_y: obb_pkg::in_t'(fy),
              first_z: obb_pkg::in_t'(fz),
              second_x: obb_pkg::in_t'(sx), second_y: obb_pkg::in_t'(sy),
              second_z: obb_pkg::in_t'(sz)};
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  // hold valid high across back-to-back requests; the caller lowers it in gaps
  task automatic send_request(obb_pkg::vec_item_t it, obb_pkg::basis_item_t want);
    vec.valid <= 1'b1;
    vec.data  <= it;
    do @(posedge clk); while (!vec.ready);
    pending_bases.push_back(want);
    accepted++;
    mode_hits[it.mode]++;
  endtask

  task automatic idle_cycles(int n);
    vec.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic int rnd_comp(int kind);
    case (kind)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 16) - 8;
      default: return ($urandom_range(0, 1) ? 32767 : -32768);
    endcase
  endfunction

  function automatic obb_pkg::vec_item_t random_request();
    obb_pkg::vec_item_t it;
    int kind, ax, k;
    it.mode = ($urandom_range(0, 19) == 0)
              ? 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
              : 4'($urandom_range(obb_pkg::MODE_U, obb_pkg::MODE_WV));
    kind = $urandom_range(0, 9);
    it.first_x = obb_pkg::in_t'(rnd_comp(kind < 6 ? 0 : (kind < 8 ? 1 : 2)));
    it.first_y = obb_pkg::in_t'(rnd_comp(kind < 6 ? 0 : (kind < 8 ? 1 : 2)));
    it.first_z = obb_pkg::in_t'(rnd_comp(kind < 6 ? 0 : (kind < 8 ? 1 : 2)));
    it.second_x = obb_pkg::in_t'(rnd_comp($urandom_range(0, 1)));
    it.second_y = obb_pkg::in_t'(rnd_comp($urandom_range(0, 1)));
    it.second_z = obb_pkg::in_t'(rnd_comp($urandom_range(0, 1)));
    case ($urandom_range(0, 11))
      0: begin it.first_x = '0; it.first_y = '0; it.first_z = '0; end
      1: begin  // nearly along one axis; along x this exercises the fallback side axis
        ax = $urandom_range(0, 2);
        it.first_x = (ax == 0) ? obb_pkg::in_t'(rnd_comp(0))
                               : obb_pkg::in_t'($urandom_range(0, 2) - 1);
        it.first_y = (ax == 1) ? obb_pkg::in_t'(rnd_comp(0))
                               : obb_pkg::in_t'($urandom_range(0, 2) - 1);
        it.first_z = (ax == 2) ? obb_pkg::in_t'(rnd_comp(0))
                               : obb_pkg::in_t'($urandom_range(0, 2) - 1);
      end
      2: begin  // near-parallel pair: raw cross product vanishes when k is 1
        k = $urandom_range(1, 3);
        it.second_x = it.first_x / k;
        it.second_y = it.first_y / k;
        it.second_z = it.first_z / k;
        if (k == 1 && $urandom_range(0, 1)) begin
          it.second_x = -it.first_x; it.second_y = -it.first_y; it.second_z = -it.first_z;
        end
      end
      3: begin it.second_x = '0; it.second_y = '0; it.second_z = '0; end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    obb_pkg::basis_item_t zero_b, x_b, want;
    obb_pkg::vec_item_t it;
    int n_rand, burst;

    errors = 0; accepted = 0; checked = 0; degen_seen = 0;
    foreach (mode_hits[i]) mode_hits[i] = 0;
    rst <= 1'b1;
    vec.valid <= 1'b0;
    vec.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    zero_b = '0;
    zero_b.degenerate = 1'b1;
    x_b = '0;
    x_b.u_x = obb_pkg::ONE_Q;
    x_b.v_z = obb_pkg::ONE_Q;
    x_b.w_y = -obb_pkg::ONE_Q;

    add_row(obb_pkg::MODE_U, 1, 0, 0, 0, 0, 0, 1, x_b);
    add_row(obb_pkg::MODE_U, 0, 0, 0, 5, 6, 7, 1, zero_b);
    add_row(MODE_SPARE_LO, 100, -3, 9, 1, 2, 3, 1, zero_b);
    add_row(MODE_SPARE_HI, -32768, 32767, -32768, 32767, -32768, 32767, 1, zero_b);
    add_row(obb_pkg::MODE_U, 32767, 32767, 32767, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_U, -32768, -32768, -32768, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_U, -32768, 1, 0, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_V, 0, 1, 0, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_V, 32767, 0, 0, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_W, -5, 0, 0, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_W, 0, 0, 0, 1, 1, 1, 0, zero_b);
    add_row(obb_pkg::MODE_UV, 1, 0, 0, 0, 1, 0, 0, zero_b);
    add_row(obb_pkg::MODE_UV, 2, 4, 6, 1, 2, 3, 0, zero_b);
    add_row(obb_pkg::MODE_VU, -32768, -32768, -32768, 32767, -32768, 32767, 0, zero_b);
    add_row(obb_pkg::MODE_VU, 0, 0, 1, 1, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_UW, 1, 0, 0, 0, 1, 0, 0, zero_b);
    add_row(obb_pkg::MODE_UW, 300, -7, 12, 0, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_WU, 0, 1, 0, 0, 0, 1, 0, zero_b);
    add_row(obb_pkg::MODE_WU, 32767, 32767, -32768, -32768, 32767, 32767, 0, zero_b);
    add_row(obb_pkg::MODE_VW, 0, 0, 1, 1, 0, 0, 0, zero_b);
    add_row(obb_pkg::MODE_VW, 0, 0, 0, 4, 5, 6, 0, zero_b);
    add_row(obb_pkg::MODE_WV, 1, 1, 0, -1, 1, 0, 0, zero_b);
    add_row(obb_pkg::MODE_WV, -32768, 0, 0, 32767, 0, 0, 0, zero_b);

    foreach (rows[i]) begin
      want = predict_basis(rows[i].req);
      if (rows[i].typed && want != rows[i].want) begin
        $error("table row %0d disagrees with predictor", i);
        errors++;
      end
      send_request(rows[i].req, rows[i].typed ? rows[i].want : want);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
    end

    // drain completely before the random part
    vec.valid <= 1'b0;
    wait (pending_bases.size() == 0);
    @(posedge clk);

    n_rand = 0;
    while (n_rand < 1200) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n_rand < 1200; b++) begin
        it = random_request();
        send_request(it, predict_basis(it));
        n_rand++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    vec.valid <= 1'b0;

    wait (pending_bases.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d results checked, %0d degenerate) over all nine modes",
             accepted, checked, degen_seen);
    $display("plus %0d requests with unused mode codes.",
             accepted - mode_hits[0] - mode_hits[1] - mode_hits[2] - mode_hits[3]
             - mode_hits[4] - mode_hits[5] - mode_hits[6] - mode_hits[7] - mode_hits[8]);
    if (errors == 0)
      $display("PASS orthonormal_basis_builder");
    else
      $display("FAIL orthonormal_basis_builder");
    $finish;
  end

endmodule
